@@ hw/rtl/hrmp_pkg.sv @@
package hrmp_pkg;

  // Flag bits in the first byte of a measurement packet
  localparam int unsigned FlagWideBit   = 0;
  localparam int unsigned FlagEnergyBit = 3;
  localparam int unsigned FlagRrBit     = 4;

  // RR interval scaling: ms = (raw * 1000 + 512) >> 10
  localparam int unsigned RrScale    = 1000;
  localparam int unsigned RrRound    = 512;
  localparam int unsigned RrShift    = 10;
  localparam int unsigned RawWidth   = 16;
  localparam int unsigned ScaleWidth = 10;
  localparam int unsigned ProdWidth  = RawWidth + ScaleWidth;

  typedef enum logic [1:0] {
    KIND_RATE = 2'd0,
    KIND_RR   = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  // Parser position inside the packet, one-hot
  typedef enum logic [7:0] {
    PH_FLAGS   = 8'b0000_0001,
    PH_RATE_LO = 8'b0000_0010,
    PH_RATE_HI = 8'b0000_0100,
    PH_EN_LO   = 8'b0000_1000,
    PH_EN_HI   = 8'b0001_0000,
    PH_RR_LO   = 8'b0010_0000,
    PH_RR_HI   = 8'b0100_0000,
    PH_DRAIN   = 8'b1000_0000
  } phase_t;

  // Convert a raw RR interval in 1/1024 s units to milliseconds
  function automatic logic [15:0] rr_to_ms(input logic [RawWidth-1:0] raw);
    logic [ProdWidth-1:0] prod;
    prod = ProdWidth'(raw) * ProdWidth'(RrScale) + ProdWidth'(RrRound);
    return prod[RrShift +: 16];
  endfunction

endpackage

@@ hw/rtl/hrmp_if.sv @@
interface hrmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface hrmp_result_if;
  import hrmp_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] value;
  logic        last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

@@ hw/rtl/heart_rate_measurement_parser_top.sv @@
// Channel | Dir | Payload                      | Beat
// in_ch   | in  | data_byte[7:0], end_of_packet | one packet byte
// out_ch  | out | kind[1:0], value[15:0], last | one parsed value or end marker
//
// One byte per cycle sustained while out_ch is ready; each byte passes through the input
// register and its result through the output register.
// The RR conversion (16x10 multiply, add, shift) sits between those two registers.
// Synchronous active-low reset returns the parser to expect a flags byte.
// A stalled output holds the input register; in_ch.ready drops only while
// the input register is full and cannot move on.
module heart_rate_measurement_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  hrmp_byte_if.sink     in_ch,
  hrmp_result_if.source out_ch
);
  import hrmp_pkg::*;

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_eop_r;

  // Parser state
  phase_t     phase_r, phase_nxt;
  logic       wide_r, wide_nxt;
  logic       energy_r, energy_nxt;
  logic       rr_r, rr_nxt;
  logic [7:0] hold_r, hold_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [15:0] out_value_r, out_value_nxt;
  logic        out_last_r, out_last_nxt;

  logic   slot_free;
  logic   proc;
  logic   have;
  kind_t  res_kind;
  logic [15:0] res_value;
  phase_t after_rate;
  phase_t after_energy;

  // Advance the input register whenever the output slot is free or draining
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign proc        = in_valid_r && slot_free;
  assign in_ch.ready = !in_valid_r || slot_free;

  assign after_rate   = energy_r ? PH_EN_LO : (rr_r ? PH_RR_LO : PH_DRAIN);
  assign after_energy = rr_r ? PH_RR_LO : PH_DRAIN;

  // Parse the registered byte
  always_comb begin
    phase_nxt  = phase_r;
    wide_nxt   = wide_r;
    energy_nxt = energy_r;
    rr_nxt     = rr_r;
    hold_nxt   = hold_r;
    have       = 1'b0;
    res_kind   = KIND_RATE;
    res_value  = '0;
    unique case (phase_r)
      PH_FLAGS: begin
        wide_nxt   = in_byte_r[FlagWideBit];
        energy_nxt = in_byte_r[FlagEnergyBit];
        rr_nxt     = in_byte_r[FlagRrBit];
        phase_nxt  = PH_RATE_LO;
      end
      PH_RATE_LO: begin
        if (wide_r) begin
          hold_nxt  = in_byte_r;
          phase_nxt = PH_RATE_HI;
        end else begin
          have      = 1'b1;
          res_value = {8'd0, in_byte_r};
          phase_nxt = after_rate;
        end
      end
      PH_RATE_HI: begin
        have      = 1'b1;
        res_value = {in_byte_r, hold_r};
        phase_nxt = after_rate;
      end
      PH_EN_LO: phase_nxt = PH_EN_HI;
      PH_EN_HI: phase_nxt = after_energy;
      PH_RR_LO: begin
        hold_nxt  = in_byte_r;
        phase_nxt = PH_RR_HI;
      end
      PH_RR_HI: begin
        have      = 1'b1;
        res_kind  = KIND_RR;
        res_value = rr_to_ms({in_byte_r, hold_r});
        phase_nxt = PH_RR_LO;
      end
      PH_DRAIN: phase_nxt = PH_DRAIN;
      default:  phase_nxt = PH_FLAGS;
    endcase
    // Drop all packet state on the final byte
    if (in_eop_r) begin
      phase_nxt  = PH_FLAGS;
      wide_nxt   = 1'b0;
      energy_nxt = 1'b0;
      rr_nxt     = 1'b0;
      hold_nxt   = '0;
    end
    if (in_eop_r && !have) begin
      res_kind  = KIND_END;
      res_value = '0;
    end
  end

  // Load the output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (proc && (have || in_eop_r)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_value_nxt = res_value;
      out_last_nxt  = in_eop_r;
    end
  end

  assign in_valid_nxt = in_ch.ready ? in_ch.valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FLAGS;
      wide_r      <= 1'b0;
      energy_r    <= 1'b0;
      rr_r        <= 1'b0;
      hold_r      <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc) begin
        phase_r  <= phase_nxt;
        wide_r   <= wide_nxt;
        energy_r <= energy_nxt;
        rr_r     <= rr_nxt;
        hold_r   <= hold_nxt;
      end
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.data_byte;
      in_eop_r  <= in_ch.end_of_packet;
    end
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.value = out_value_r;
  assign out_ch.last  = out_last_r;

  // A processed final byte always leaves the parser expecting flags
  a_eop_resets: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_eop_r |=> phase_r == PH_FLAGS && !wide_r && !energy_r && !rr_r)
    else $error("parser state not cleared after final byte");

  // A processed final byte always produces a result
  a_eop_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_eop_r |=> out_valid_r && out_last_r)
    else $error("final byte gave no last result");

  // End marker carries zero and closes the packet
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_END |-> out_value_r == 16'd0 && out_last_r)
    else $error("malformed end marker");

  // Scaled RR interval cannot exceed 64000 ms
  a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_RR |-> out_value_r <= 16'd64000)
    else $error("RR interval out of range");

  // Backpressure only while a byte is held
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_valid_r && out_valid_r)
    else $error("input stalled without cause");

endmodule

@@ tb/heart_rate_measurement_parser_top_tb.sv @@
`timescale 1ns / 100ps

module heart_rate_measurement_parser_top_tb;
  import hrmp_pkg::*;

  localparam int ItemTarget  = 1700;
  localparam int CycleLimit  = 200000;
  localparam int IdlePercent = 23;
  localparam int DrainCycles = 20;
  localparam int ReportMax   = 10;

  // How a beat's result is judged: from the predictor, as none, or as typed in the table
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_GIVEN = 2'd2
  } row_check_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        eop;
    row_check_e  how;
    kind_t       kind;
    logic [15:0] value;
    logic        last;
  } stim_row_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        last;
  } hr_result_t;

  localparam stim_row_t ByModel = '{8'h00, 1'b0, CHK_MODEL, KIND_RATE, 16'd0, 1'b0};

  // Directed packets; typed-in results only where they are obvious
  stim_row_t directed_rows [28] = '{
    // flags byte alone
    '{8'h00, 1'b1, CHK_GIVEN, KIND_END,  16'd0,     1'b1},
    // narrow rate completed on the final byte
    '{8'h00, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'hFF, 1'b1, CHK_GIVEN, KIND_RATE, 16'd255,   1'b1},
    // narrow rate, trailing byte without RR is ignored
    '{8'h00, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h00, 1'b0, CHK_GIVEN, KIND_RATE, 16'd0,     1'b0},
    '{8'h55, 1'b1, CHK_GIVEN, KIND_END,  16'd0,     1'b1},
    // wide rate at its maximum
    '{8'h01, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'hFF, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'hFF, 1'b1, CHK_GIVEN, KIND_RATE, 16'd65535, 1'b1},
    // half a wide rate at packet end
    '{8'h01, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h34, 1'b1, CHK_GIVEN, KIND_END,  16'd0,     1'b1},
    // half an energy field at packet end
    '{8'h08, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h10, 1'b0, CHK_GIVEN, KIND_RATE, 16'd16,    1'b0},
    '{8'h99, 1'b1, CHK_GIVEN, KIND_END,  16'd0,     1'b1},
    // every flag bit set: wide rate, energy skipped, RR extremes
    '{8'hFF, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h48, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h00, 1'b0, CHK_GIVEN, KIND_RATE, 16'd72,    1'b0},
    '{8'h11, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h22, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h00, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h04, 1'b0, CHK_GIVEN, KIND_RR,   16'd1000,  1'b0},
    '{8'hFF, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'hFF, 1'b0, CHK_GIVEN, KIND_RR,   16'd63999, 1'b0},
    '{8'h00, 1'b0, CHK_NONE,  KIND_RATE, 16'd0,     1'b0},
    '{8'h00, 1'b1, CHK_GIVEN, KIND_RR,   16'd0,     1'b1},
    // narrow rate with RR, half an interval at packet end
    '{8'h10, 1'b0, CHK_MODEL, KIND_RATE, 16'd0,     1'b0},
    '{8'h5A, 1'b0, CHK_MODEL, KIND_RATE, 16'd0,     1'b0},
    '{8'h33, 1'b1, CHK_GIVEN, KIND_END,  16'd0,     1'b1}
  };

  logic clk;
  logic rst_n;
  logic no_gaps;
  int   items_sent;
  int   cycle_count;
  int   mismatch_count;

  stim_row_t  row_check_q [$];
  hr_result_t pending_results [$];

  // Parser state as the testbench tracks it
  phase_t     pos;
  logic       wide_rate;
  logic       energy_follows;
  logic       rr_follows;
  logic [7:0] held_low;

  hrmp_byte_if   byte_ch ();
  hrmp_result_if result_ch ();

  heart_rate_measurement_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (result_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void flag_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= ReportMax) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic phase_t phase_after_rate();
    if (energy_follows) return PH_EN_LO;
    if (rr_follows) return PH_RR_LO;
    return PH_DRAIN;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic eop,
                                    output hr_result_t res);
    bit          made;
    logic [31:0] prod;
    made = 1'b0;
    res  = '{KIND_RATE, 16'd0, 1'b0};
    case (pos)
      PH_FLAGS: begin
        wide_rate      = b[FlagWideBit];
        energy_follows = b[FlagEnergyBit];
        rr_follows     = b[FlagRrBit];
        pos            = PH_RATE_LO;
      end
      PH_RATE_LO: begin
        if (wide_rate) begin
          held_low = b;
          pos      = PH_RATE_HI;
        end else begin
          made      = 1'b1;
          res.kind  = KIND_RATE;
          res.value = {8'h00, b};
          pos       = phase_after_rate();
        end
      end
      PH_RATE_HI: begin
        made      = 1'b1;
        res.kind  = KIND_RATE;
        res.value = {b, held_low};
        pos       = phase_after_rate();
      end
      PH_EN_LO: pos = PH_EN_HI;
      PH_EN_HI: pos = rr_follows ? PH_RR_LO : PH_DRAIN;
      PH_RR_LO: begin
        held_low = b;
        pos      = PH_RR_HI;
      end
      PH_RR_HI: begin
        // 1/1024 s units to ms, rounded
        prod      = {16'h0000, b, held_low} * 32'd1000 + 32'd512;
        made      = 1'b1;
        res.kind  = KIND_RR;
        res.value = prod[25:10];
        pos       = PH_RR_LO;
      end
      default: ;
    endcase
    // Close the packet: one result with last, end marker if nothing completed
    if (eop) begin
      pos            = PH_FLAGS;
      wide_rate      = 1'b0;
      energy_follows = 1'b0;
      rr_follows     = 1'b0;
      held_low       = 8'h00;
      if (!made) begin
        res.kind  = KIND_END;
        res.value = 16'd0;
      end
      res.last = 1'b1;
      made     = 1'b1;
    end
    return made;
  endfunction

  // Predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin : scoreboard
    stim_row_t  row;
    hr_result_t res;
    hr_result_t want;
    bit         made;
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          flag_failure($sformatf("unexpected result kind=%0d value=%0d last=%0b",
                                 result_ch.kind, result_ch.value, result_ch.last));
        end else begin
          want = pending_results.pop_front();
          if (result_ch.kind !== want.kind || result_ch.value !== want.value ||
              result_ch.last !== want.last) begin
            flag_failure($sformatf({"result mismatch: expected kind=%0d value=%0d ",
                                    "last=%0b, got kind=%0d value=%0d last=%0b"},
                                   want.kind, want.value, want.last,
                                   result_ch.kind, result_ch.value, result_ch.last));
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) begin
        row  = row_check_q.pop_front();
        made = parse_byte(byte_ch.data_byte, byte_ch.end_of_packet, res);
        case (row.how)
          CHK_MODEL: if (made) pending_results.insert(pending_results.size(), res);
          CHK_GIVEN: begin
            want = '{row.kind, row.value, row.last};
            pending_results.insert(pending_results.size(), want);
          end
          default: ;
        endcase
      end
    end
  end

  // Stall the result side at random
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready = no_gaps || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("heart_rate_measurement_parser_top regression: fail");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Present one beat from a falling edge; return at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eop, input stim_row_t chk);
    while (!no_gaps && $urandom_range(0, 99) < IdlePercent) begin
      byte_ch.valid     = 1'b0;
      byte_ch.data_byte = 8'($urandom);
      @(negedge clk);
    end
    row_check_q.insert(row_check_q.size(), chk);
    byte_ch.valid         = 1'b1;
    byte_ch.data_byte     = b;
    byte_ch.end_of_packet = eop;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
  endtask

  // Mostly well-formed packets with random content, some truncated, some noise
  task automatic send_packet();
    logic [7:0] bytes [$];
    logic [7:0] flags;
    int         n_rr;
    int         extra;
    int         roll;
    roll  = $urandom_range(0, 99);
    extra = 0;
    if (roll < 15) begin
      repeat ($urandom_range(1, 8)) bytes.insert(bytes.size(), pick_byte());
    end else begin
      flags = 8'($urandom);
      bytes.insert(bytes.size(), flags);
      bytes.insert(bytes.size(), pick_byte());
      if (flags[FlagWideBit]) bytes.insert(bytes.size(), pick_byte());
      if (flags[FlagEnergyBit]) repeat (2) bytes.insert(bytes.size(), pick_byte());
      if (flags[FlagRrBit]) begin
        n_rr = $urandom_range(0, 4);
        repeat (2 * n_rr) bytes.insert(bytes.size(), pick_byte());
      end
      if ($urandom_range(0, 99) < 35) begin
        extra = $urandom_range(1, 3);
        repeat (extra) bytes.insert(bytes.size(), pick_byte());
      end
      // Cut the packet short now and then
      if (roll < 30) begin
        extra = 0;
        bytes = bytes[0 : $urandom_range(0, bytes.size() - 1)];
      end
    end
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, ByModel);
    items_sent += bytes.size();
  endtask

  initial begin
    rst_n                 = 1'b0;
    no_gaps               = 1'b0;
    items_sent            = 0;
    mismatch_count        = 0;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = 8'h00;
    byte_ch.end_of_packet = 1'b0;
    pos                   = PH_FLAGS;
    wide_rate             = 1'b0;
    energy_follows        = 1'b0;
    rr_follows            = 1'b0;
    held_low              = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].eop, directed_rows[i]);
    end

    // Random packets, with a stretch of full-rate traffic on both sides
    while (items_sent < ItemTarget) begin
      no_gaps = (items_sent >= 600 && items_sent < 900);
      send_packet();
    end
    no_gaps       = 1'b0;
    byte_ch.valid = 1'b0;

    // Drain outstanding results, then give stray beats a chance to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("heart_rate_measurement_parser_top regression: pass");
    end else begin
      $display("heart_rate_measurement_parser_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hrmp_pkg.sv
hw/rtl/hrmp_if.sv
hw/rtl/heart_rate_measurement_parser_top.sv
tb/heart_rate_measurement_parser_top_tb.sv
